[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL. All checks run on the rising edge of clk
// and are switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled every clock
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/chb_pkg.sv]
`timescale 1ns / 1ps

package chb_pkg;

  // Input transfer: one body byte or a restart
  typedef struct packed {
    logic       operation;
    logic [7:0] in_byte;
  } in_item_t;

  // Result transfer
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       body_done;
    logic [1:0] status;
  } result_t;

  // Operation codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_UNUSED    = 2'd3;

  // Line-ending characters
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

endpackage

[rtl/core/chb_engine.sv]
`timescale 1ns / 1ps

module chb_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [63:0]      cfg_wdata,
  input  logic             step_en,
  input  chb_pkg::in_item_t item,
  output chb_pkg::result_t  result
);
  import chb_pkg::*;

  typedef enum logic [3:0] {
    PH_SIZE_FIRST,
    PH_SIZE_MORE,
    PH_EXT,
    PH_EXT_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_TRL_START,
    PH_TRL_END_LF,
    PH_TRL_LINE,
    PH_TRL_LINE_LF,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [63:0] chunk_remaining, chunk_remaining_next;
  logic [63:0] body_count, body_count_next;
  logic [1:0]  sticky_status, sticky_status_next;
  logic [63:0] byte_cap;

  logic       hex_ok;
  logic [3:0] hex_nib;
  logic [7:0] c;

  assign c = item.in_byte;

  // Hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_nib = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_nib = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_nib = 4'(c - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Framing step for one byte
  always_comb begin
    phase_next           = phase;
    chunk_remaining_next = chunk_remaining;
    body_count_next      = body_count;
    sticky_status_next   = sticky_status;
    result               = '0;

    if (item.operation == OP_RESTART) begin
      phase_next           = PH_SIZE_FIRST;
      chunk_remaining_next = '0;
      body_count_next      = '0;
      sticky_status_next   = ST_OK;
    end else if (sticky_status == ST_OK && phase != PH_DONE) begin
      unique case (phase)
        PH_SIZE_FIRST: begin
          if (!hex_ok) begin
            sticky_status_next = ST_MALFORMED;
          end else begin
            chunk_remaining_next = {60'd0, hex_nib};
            phase_next           = PH_SIZE_MORE;
          end
        end
        PH_SIZE_MORE: begin
          if (hex_ok) begin
            // size must stay within 64 bits after the shift
            if (|chunk_remaining[63:60]) begin
              sticky_status_next = ST_MALFORMED;
            end else begin
              chunk_remaining_next = {chunk_remaining[59:0], hex_nib};
            end
          end else begin
            phase_next = (c == CH_CR) ? PH_EXT_LF : PH_EXT;
          end
        end
        PH_EXT: begin
          if (c == CH_CR) phase_next = PH_EXT_LF;
        end
        PH_EXT_LF: begin
          if (c != CH_LF) begin
            sticky_status_next = ST_MALFORMED;
          end else begin
            phase_next = (chunk_remaining == '0) ? PH_TRL_START : PH_DATA;
          end
        end
        PH_DATA: begin
          if (body_count >= byte_cap) begin
            sticky_status_next = ST_TOO_LARGE;
          end else begin
            result.data_valid    = 1'b1;
            result.data_byte     = c;
            body_count_next      = body_count + 64'd1;
            chunk_remaining_next = chunk_remaining - 64'd1;
            if (chunk_remaining == 64'd1) phase_next = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (c != CH_CR) sticky_status_next = ST_MALFORMED;
          else phase_next = PH_DATA_LF;
        end
        PH_DATA_LF: begin
          if (c != CH_LF) sticky_status_next = ST_MALFORMED;
          else phase_next = PH_SIZE_FIRST;
        end
        PH_TRL_START: begin
          phase_next = (c == CH_CR) ? PH_TRL_END_LF : PH_TRL_LINE;
        end
        PH_TRL_END_LF: begin
          if (c != CH_LF) sticky_status_next = ST_MALFORMED;
          else phase_next = PH_DONE;
        end
        PH_TRL_LINE: begin
          if (c == CH_CR) phase_next = PH_TRL_LINE_LF;
        end
        PH_TRL_LINE_LF: begin
          if (c != CH_LF) sticky_status_next = ST_MALFORMED;
          else phase_next = PH_TRL_START;
        end
        default: begin
          sticky_status_next = ST_MALFORMED;
        end
      endcase
    end

    if (item.operation == OP_BYTE) begin
      result.status    = sticky_status_next;
      result.body_done = (sticky_status_next == ST_OK) && (phase_next == PH_DONE);
    end
  end

  // State and limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE_FIRST;
      chunk_remaining <= '0;
      body_count      <= '0;
      sticky_status   <= ST_OK;
      byte_cap        <= '1;
    end else begin
      if (step_en) begin
        phase           <= phase_next;
        chunk_remaining <= chunk_remaining_next;
        body_count      <= body_count_next;
        sticky_status   <= sticky_status_next;
      end
      if (cfg_wen) byte_cap <= cfg_wdata;
    end
  end

endmodule

[rtl/core/http_chunked_body_deframer_unit.sv]
`timescale 1ns / 1ps
// Chunked body deframer: one result transfer per input transfer.
// Throughput: one byte per cycle while out_stall is low; the framing step is combinational.
// Each input transfer passes through the input register, then its result through the result register.
// Reset (rst, synchronous): framing state cleared, body limit set to all ones,
// both pipeline registers emptied.

module http_chunked_body_deframer_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  chb_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output chb_pkg::result_t  out_data,
  input  logic              cfg_wen,
  input  logic [63:0]       cfg_wdata
);
  import chb_pkg::*;

  logic     in_reg_v;
  in_item_t in_reg;
  logic     advance;
  logic     in_take;
  result_t  step_res;

  // Step when an item waits and the result register is free or draining
  assign advance  = in_reg_v && (!out_valid || !out_stall);
  assign in_stall = in_reg_v && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_v <= 1'b0;
    end else if (in_take) begin
      in_reg_v <= 1'b1;
    end else if (advance) begin
      in_reg_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_reg <= in_data;
  end

  chb_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .step_en   (advance),
    .item      (in_reg),
    .result    (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data <= step_res;
  end

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_data_ok, out_valid && out_data.data_valid, out_data.status == ST_OK && !out_data.body_done, "payload byte with error or done flag")
  `ASSERT_IMPL(a_byte_zero, out_valid && !out_data.data_valid, out_data.data_byte == 8'd0, "data byte set without payload")
  `ASSERT_IMPL(a_done_ok, out_valid && out_data.body_done, out_data.status == ST_OK, "done flag with error status")
  `ASSERT_CLK(a_status_code, !out_valid || out_data.status != ST_UNUSED, "unused status code")
  `ASSERT_IMPL(a_stall_full, in_stall, in_reg_v && out_valid && out_stall, "input stalled without backpressure")

endmodule
